[sv/point_in_view_frustum_test_assert.svh]
// Assertion macros for the point-in-view-frustum test.
// Included by the top level; needs nothing else.
`ifndef POINT_IN_VIEW_FRUSTUM_TEST_ASSERT_SVH
`define POINT_IN_VIEW_FRUSTUM_TEST_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PIFT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frustum test assertion failed");

// Next-cycle implication, disabled during reset.
`define PIFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frustum test assertion failed");

`endif

[sv/pift_pkg.sv]
// Shared widths, register codes, reset values and helpers for the frustum test.
// No dependencies.
package pift_pkg;

  localparam int COORD_W = 16;   // Q8.8 coordinate
  localparam int OFF_W   = 17;   // point minus light, exact
  localparam int PP_W    = 33;   // one offset-by-axis product
  localparam int DOT_W   = 35;   // sum of three products
  localparam int MAG_W   = 33;   // magnitude of a projection
  localparam int NORM_W  = 32;   // squared axis length
  localparam int SQ_W    = 66;   // squared magnitude
  localparam int PROD_W  = 98;   // squared magnitude times squared length
  localparam int CFG_W   = 48;
  localparam int IDX_W   = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_LIGHT_POS = 3'd0,
    REG_AXIS_RT   = 3'd1,
    REG_AXIS_UP   = 3'd2,
    REG_AXIS_FWD  = 3'd3,
    REG_NEAR      = 3'd4,
    REG_FAR       = 3'd5
  } reg_idx_t;

  localparam logic [CFG_W-1:0]   RST_LIGHT_POS = 48'd0;
  localparam logic [CFG_W-1:0]   RST_AXIS_RT   = 48'd256;
  localparam logic [CFG_W-1:0]   RST_AXIS_UP   = 48'd16777216;
  localparam logic [CFG_W-1:0]   RST_AXIS_FWD  = 48'd1099511627776;
  localparam logic [COORD_W-1:0] RST_NEAR      = 16'h0000;
  localparam logic [COORD_W-1:0] RST_FAR       = 16'h7FFF;

  // Sign information that travels beside the squared products.
  typedef struct packed {
    logic axis_zero;
    logic near_pos;
    logic far_neg;
    logic depth_pos;
    logic depth_neg;
  } side_t;

  function automatic logic signed [COORD_W-1:0] lane(input logic [CFG_W-1:0] p,
                                                     input int i);
    return $signed(p[COORD_W*i +: COORD_W]);
  endfunction

  // Decides a*sqrt(s1) <= b*sqrt(s2) from the signs and the squared sides.
  function automatic logic le_roots(input logic a_pos, input logic b_neg,
                                    input logic [PROD_W-1:0] l,
                                    input logic [PROD_W-1:0] r);
    logic res;
    if (!a_pos && !b_neg) begin
      res = 1'b1;
    end else if (a_pos && b_neg) begin
      res = 1'b0;
    end else if (a_pos) begin
      res = (l <= r);
    end else begin
      res = (l >= r);
    end
    return res;
  endfunction

endpackage

[sv/pift_point_if.sv]
// Input channel carrying one world point per beat.
// Uses pift_pkg for the coordinate width.
interface pift_point_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pift_pkg::COORD_W-1:0]  point_x;
  logic signed [pift_pkg::COORD_W-1:0]  point_y;
  logic signed [pift_pkg::COORD_W-1:0]  point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

[sv/pift_result_if.sv]
// Output channel carrying one inside/outside flag per beat.
// No dependencies.
interface pift_result_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

[sv/pift_sqscale.sv]
// Four-stage pipelined unit computing mag^2 * scale exactly.
// Uses pift_pkg widths; advances only when en is high.
module pift_sqscale (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pift_pkg::MAG_W-1:0]    mag,
  input  logic [pift_pkg::NORM_W-1:0]   scale,
  output logic [pift_pkg::PROD_W-1:0]   prod
);
  localparam int LO_W = 16;
  localparam int HI_W = pift_pkg::MAG_W - LO_W;
  localparam int CH_W = 22;
  localparam int PR_W = CH_W + pift_pkg::NORM_W;

  logic [2*HI_W-1:0]            pa;
  logic [HI_W+LO_W-1:0]         pb;
  logic [2*LO_W-1:0]            pc;
  logic [pift_pkg::NORM_W-1:0]  s_a;
  logic [pift_pkg::SQ_W-1:0]    sq;
  logic [pift_pkg::NORM_W-1:0]  s_b;
  logic [PR_W-1:0]              r0, r1, r2;

  always_ff @(posedge clk) begin
    if (en) begin
      // Split the magnitude into a 17-bit high and a 16-bit low half.
      pa  <= mag[pift_pkg::MAG_W-1:LO_W] * mag[pift_pkg::MAG_W-1:LO_W];
      pb  <= mag[pift_pkg::MAG_W-1:LO_W] * mag[LO_W-1:0];
      pc  <= mag[LO_W-1:0] * mag[LO_W-1:0];
      s_a <= scale;
      sq  <= (pift_pkg::SQ_W'(pa) << (2*LO_W)) + (pift_pkg::SQ_W'(pb) << (LO_W+1))
             + pift_pkg::SQ_W'(pc);
      s_b <= s_a;
      r0  <= PR_W'(sq[CH_W-1:0] * s_b);
      r1  <= PR_W'(sq[2*CH_W-1:CH_W] * s_b);
      r2  <= PR_W'(sq[pift_pkg::SQ_W-1:2*CH_W] * s_b);
      prod <= (pift_pkg::PROD_W'(r2) << (2*CH_W)) + (pift_pkg::PROD_W'(r1) << CH_W)
              + pift_pkg::PROD_W'(r0);
    end
  end
endmodule

[sv/point_in_view_frustum_test.sv]
// Top level of the point-in-view-frustum test: config registers, projection
// pipeline and final decision. Uses pift_pkg, the two channel interfaces,
// pift_sqscale and the assertion header.
//
//   channel   | role | payload
//   ----------+------+--------------------------------------
//   point     | in   | point_x, point_y, point_z (Q8.8)
//   result    | out  | inside_res
//   wr_*      | in   | wr_index, wr_data (no handshake)
//
// One point enters per cycle unless the result side stalls; its flag passes
// through the offset, product and sum stages, the four-stage squaring unit
// and the output register. Reset is synchronous and clears the valid bits
// and the configuration registers to their defaults. A stall on the result
// side freezes the whole pipeline, and point.ready falls with it.

`include "point_in_view_frustum_test_assert.svh"

module point_in_view_frustum_test (
  input  logic                           clk,
  input  logic                           rst,
  pift_point_if.sink                     point,
  pift_result_if.source                  result,
  input  logic                           wr_en,
  input  logic [pift_pkg::IDX_W-1:0]     wr_index,
  input  logic [pift_pkg::CFG_W-1:0]     wr_data
);
  localparam int OFF_W = pift_pkg::OFF_W;
  localparam int PP_W  = pift_pkg::PP_W;
  localparam int DOT_W = pift_pkg::DOT_W;
  localparam int MAG_W = pift_pkg::MAG_W;
  localparam int NRM_W = pift_pkg::NORM_W;
  localparam int PRD_W = pift_pkg::PROD_W;
  localparam int SQL_W = 32;   // square of one lane

  // Configuration registers.
  logic [pift_pkg::CFG_W-1:0]    light_position, axis_r, axis_u, axis_f;
  logic [pift_pkg::COORD_W-1:0]  near_clip, far_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_position <= pift_pkg::RST_LIGHT_POS;
      axis_r         <= pift_pkg::RST_AXIS_RT;
      axis_u         <= pift_pkg::RST_AXIS_UP;
      axis_f         <= pift_pkg::RST_AXIS_FWD;
      near_clip      <= pift_pkg::RST_NEAR;
      far_clip       <= pift_pkg::RST_FAR;
    end else if (wr_en) begin
      unique case (pift_pkg::reg_idx_t'(wr_index))
        pift_pkg::REG_LIGHT_POS: light_position <= wr_data;
        pift_pkg::REG_AXIS_RT:   axis_r <= wr_data;
        pift_pkg::REG_AXIS_UP:   axis_u <= wr_data;
        pift_pkg::REG_AXIS_FWD:  axis_f <= wr_data;
        pift_pkg::REG_NEAR:      near_clip <= wr_data[pift_pkg::COORD_W-1:0];
        pift_pkg::REG_FAR:       far_clip <= wr_data[pift_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together whenever the output register can take a beat.
  logic       en;
  logic [7:1] vld;
  logic       res_valid, res_inside;

  assign en           = !res_valid || result.ready;
  assign point.ready  = en;
  assign result.valid = res_valid;
  assign result.inside_res = res_inside;

  // Stage 1: offset of the point from the light origin.
  logic signed [OFF_W-1:0] off [3];
  // Stage 2: offset-by-axis products and squared axis lanes.
  logic signed [PP_W-1:0]  pf [3], pu [3], pr [3];
  logic signed [SQL_W-1:0] qf [3], qu [3], qr [3];
  // Stage 3: projections, magnitudes and squared lengths.
  logic [MAG_W-1:0]        depth_mag, up_mag, rt_mag, near_mag, far_mag;
  logic [NRM_W-1:0]        sf, su, sr;
  pift_pkg::side_t         side [3:7];

  logic signed [DOT_W-1:0] depth_c, up_c, rt_c;
  logic [NRM_W:0]          sf_c, su_c, sr_c;
  logic signed [OFF_W-1:0] near_s, far_s;

  always_comb begin
    depth_c = -(DOT_W'(pf[0]) + DOT_W'(pf[1]) + DOT_W'(pf[2]));
    up_c    = DOT_W'(pu[0]) + DOT_W'(pu[1]) + DOT_W'(pu[2]);
    rt_c    = DOT_W'(pr[0]) + DOT_W'(pr[1]) + DOT_W'(pr[2]);
    sf_c    = (NRM_W+1)'($unsigned(qf[0])) + (NRM_W+1)'($unsigned(qf[1]))
              + (NRM_W+1)'($unsigned(qf[2]));
    su_c    = (NRM_W+1)'($unsigned(qu[0])) + (NRM_W+1)'($unsigned(qu[1]))
              + (NRM_W+1)'($unsigned(qu[2]));
    sr_c    = (NRM_W+1)'($unsigned(qr[0])) + (NRM_W+1)'($unsigned(qr[1]))
              + (NRM_W+1)'($unsigned(qr[2]));
    near_s  = OFF_W'($signed(near_clip));
    far_s   = OFF_W'($signed(far_clip));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pf[i] <= PP_W'(off[i] * pift_pkg::lane(axis_f, i));
        pu[i] <= PP_W'(off[i] * pift_pkg::lane(axis_u, i));
        pr[i] <= PP_W'(off[i] * pift_pkg::lane(axis_r, i));
        qf[i] <= SQL_W'(pift_pkg::lane(axis_f, i) * pift_pkg::lane(axis_f, i));
        qu[i] <= SQL_W'(pift_pkg::lane(axis_u, i) * pift_pkg::lane(axis_u, i));
        qr[i] <= SQL_W'(pift_pkg::lane(axis_r, i) * pift_pkg::lane(axis_r, i));
      end
      off[0] <= OFF_W'(point.point_x) - OFF_W'(pift_pkg::lane(light_position, 0));
      off[1] <= OFF_W'(point.point_y) - OFF_W'(pift_pkg::lane(light_position, 1));
      off[2] <= OFF_W'(point.point_z) - OFF_W'(pift_pkg::lane(light_position, 2));

      depth_mag <= MAG_W'(depth_c < 0 ? -depth_c : depth_c);
      up_mag    <= MAG_W'(up_c < 0 ? -up_c : up_c);
      rt_mag    <= MAG_W'(rt_c < 0 ? -rt_c : rt_c);
      near_mag  <= MAG_W'(near_s < 0 ? -near_s : near_s);
      far_mag   <= MAG_W'(far_s < 0 ? -far_s : far_s);
      sf <= sf_c[NRM_W-1:0];
      su <= su_c[NRM_W-1:0];
      sr <= sr_c[NRM_W-1:0];

      // Signs ride alongside the four-stage squaring units.
      side[3].axis_zero <= (axis_f == '0) || (axis_u == '0) || (axis_r == '0);
      side[3].near_pos  <= near_s > 0;
      side[3].far_neg   <= far_s < 0;
      side[3].depth_pos <= depth_c > 0;
      side[3].depth_neg <= depth_c < 0;
      for (int k = 4; k <= 7; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // Squared, scaled sides of the four comparisons.
  logic [PRD_W-1:0] l_near, d_sq, r_far, l_up, r_up, l_rt, r_rt;

  pift_sqscale u_near (.clk, .en, .mag(near_mag),  .scale(sf),       .prod(l_near));
  pift_sqscale u_dsq  (.clk, .en, .mag(depth_mag), .scale(NRM_W'(1)), .prod(d_sq));
  pift_sqscale u_far  (.clk, .en, .mag(far_mag),   .scale(sf),       .prod(r_far));
  pift_sqscale u_up   (.clk, .en, .mag(up_mag),    .scale(sf),       .prod(l_up));
  pift_sqscale u_dup  (.clk, .en, .mag(depth_mag), .scale(su),       .prod(r_up));
  pift_sqscale u_rt   (.clk, .en, .mag(rt_mag),    .scale(sf),       .prod(l_rt));
  pift_sqscale u_drt  (.clk, .en, .mag(depth_mag), .scale(sr),       .prod(r_rt));

  // Near and far bounds follow the signs; the up and right bounds need a
  // non-negative depth, after which the squared comparison decides.
  logic c_near, c_far, c_up, c_rt, inside_c;

  always_comb begin
    c_near   = pift_pkg::le_roots(side[7].near_pos, side[7].depth_neg, l_near, d_sq);
    c_far    = pift_pkg::le_roots(side[7].depth_pos, side[7].far_neg, d_sq, r_far);
    c_up     = !side[7].depth_neg && (l_up <= r_up);
    c_rt     = !side[7].depth_neg && (l_rt <= r_rt);
    inside_c = !side[7].axis_zero && c_near && c_far && c_up && c_rt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[6:1], point.valid};
      res_valid <= vld[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_inside <= inside_c;
    end
  end

  `PIFT_ASSERT_NOW(a_stall_blocks_input, clk, rst, result.valid && !result.ready, !point.ready)
  `PIFT_ASSERT_NOW(a_inside_needs_axes, clk, rst, result.valid && result.inside_res, (axis_f != '0) && (axis_u != '0) && (axis_r != '0))
  `PIFT_ASSERT_NOW(a_inside_needs_order, clk, rst, result.valid && result.inside_res, $signed(near_clip) <= $signed(far_clip))
  `PIFT_ASSERT_NEXT(a_bubble_drains, clk, rst, en && !vld[7], !res_valid)

endmodule

[verif/point_in_view_frustum_test_checker.sv]
`timescale 1ns / 1ps
// Checker for the frustum test: tracks the config writes, predicts the inside
// flag of every accepted point and compares it with each result beat.
// Depends on pift_pkg and the two channel interfaces.
module point_in_view_frustum_test_checker (
  input  logic                       clk,
  input  logic                       rst,
  pift_point_if                      pt,
  pift_result_if                     res,
  input  logic                       wr_en,
  input  logic [pift_pkg::IDX_W-1:0] wr_index,
  input  logic [pift_pkg::CFG_W-1:0] wr_data,
  output int                         fail_count,
  output int                         flags_pending
);
  logic [pift_pkg::CFG_W-1:0]   light_q, right_q, up_q, fwd_q;
  logic [pift_pkg::COORD_W-1:0] near_q, far_q;
  bit                           flag_q[$];

  function automatic longint coord(input logic [pift_pkg::CFG_W-1:0] p, input int i);
    logic signed [pift_pkg::COORD_W-1:0] v;
    v = p[pift_pkg::COORD_W*i +: pift_pkg::COORD_W];
    return longint'(v);
  endfunction

  function automatic longint axis_dot(input longint o[3],
                                      input logic [pift_pkg::CFG_W-1:0] ax);
    return o[0] * coord(ax, 0) + o[1] * coord(ax, 1) + o[2] * coord(ax, 2);
  endfunction

  function automatic longint axis_len_sq(input logic [pift_pkg::CFG_W-1:0] ax);
    return coord(ax, 0) ** 2 + coord(ax, 1) ** 2 + coord(ax, 2) ** 2;
  endfunction

  // Exact a*sqrt(s1) <= b*sqrt(s2) for positive s1, s2.
  function automatic bit scaled_le(input longint a, input longint s1,
                                   input longint b, input longint s2);
    logic [127:0] ma, mb, lhs, rhs;
    if (a <= 0 && b >= 0) return 1'b1;
    if (a > 0 && b < 0) return 1'b0;
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    lhs = ma * ma * s1;
    rhs = mb * mb * s2;
    return (a > 0) ? (lhs <= rhs) : (lhs >= rhs);
  endfunction

  function automatic bit frustum_inside(input logic signed [pift_pkg::COORD_W-1:0] x,
                                        input logic signed [pift_pkg::COORD_W-1:0] y,
                                        input logic signed [pift_pkg::COORD_W-1:0] z);
    longint o[3];
    longint sf, su, sr, depth, up_p, rt_p, nv, fv;
    o[0] = longint'(x) - coord(light_q, 0);
    o[1] = longint'(y) - coord(light_q, 1);
    o[2] = longint'(z) - coord(light_q, 2);
    sf = axis_len_sq(fwd_q);
    su = axis_len_sq(up_q);
    sr = axis_len_sq(right_q);
    if (sf == 0 || su == 0 || sr == 0) return 1'b0;
    depth = -axis_dot(o, fwd_q);
    up_p  = axis_dot(o, up_q);
    rt_p  = axis_dot(o, right_q);
    if (up_p < 0) up_p = -up_p;
    if (rt_p < 0) rt_p = -rt_p;
    nv = longint'($signed(near_q));
    fv = longint'($signed(far_q));
    return scaled_le(nv, sf, depth, 1) && scaled_le(depth, 1, fv, sf) &&
           scaled_le(up_p, sf, depth, su) && scaled_le(rt_p, sf, depth, sr);
  endfunction

  assign flags_pending = flag_q.size();

  always @(posedge clk) begin
    if (rst) begin
      light_q    <= pift_pkg::RST_LIGHT_POS;
      right_q    <= pift_pkg::RST_AXIS_RT;
      up_q       <= pift_pkg::RST_AXIS_UP;
      fwd_q      <= pift_pkg::RST_AXIS_FWD;
      near_q     <= pift_pkg::RST_NEAR;
      far_q      <= pift_pkg::RST_FAR;
      flag_q.delete();
      fail_count <= 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          pift_pkg::REG_LIGHT_POS: light_q <= wr_data;
          pift_pkg::REG_AXIS_RT:   right_q <= wr_data;
          pift_pkg::REG_AXIS_UP:   up_q    <= wr_data;
          pift_pkg::REG_AXIS_FWD:  fwd_q   <= wr_data;
          pift_pkg::REG_NEAR:      near_q  <= wr_data[pift_pkg::COORD_W-1:0];
          pift_pkg::REG_FAR:       far_q   <= wr_data[pift_pkg::COORD_W-1:0];
          default: ;
        endcase
      end
      if (pt.valid && pt.ready)
        flag_q.push_back(frustum_inside(pt.point_x, pt.point_y, pt.point_z));
      if (res.valid && res.ready) begin
        if (flag_q.size() == 0) begin
          $error("inside_res: beat with no point outstanding, actual %0b", res.inside_res);
          fail_count <= fail_count + 1;
        end else if (flag_q[0] !== res.inside_res) begin
          $error("inside_res: expected %0b, actual %0b", flag_q[0], res.inside_res);
          fail_count <= fail_count + 1;
          void'(flag_q.pop_front());
        end else begin
          void'(flag_q.pop_front());
        end
      end
    end
  end
endmodule

[verif/point_in_view_frustum_test_tb.sv]
`timescale 1ns / 1ps
// Top of the frustum test bench: clock, reset, point stimulus, result-side
// back-pressure and the verdict. Depends on pift_pkg, both channel interfaces,
// the block and point_in_view_frustum_test_checker.
module point_in_view_frustum_test_tb;
  localparam int IDX_W = pift_pkg::IDX_W;
  localparam int CFG_W = pift_pkg::CFG_W;

  // Indexes past the register list; writes to them must be dropped.
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;
  // Pipeline depth is 8; idle margin after the last result of each drain.
  localparam int DRAIN_CYCLES = 12;

  logic             clk;
  logic             rst;
  logic             wr_en;
  logic [IDX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;
  int               fail_count;
  int               flags_pending;
  bit               steady;      // no idling on either side while set
  int               stall_left;  // long hold-off on the result side

  pift_point_if  pt();
  pift_result_if res();

  point_in_view_frustum_test dut (
    .clk(clk), .rst(rst), .point(pt), .result(res),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  point_in_view_frustum_test_checker chk (
    .clk(clk), .rst(rst), .pt(pt), .res(res),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .fail_count(fail_count), .flags_pending(flags_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The run is bounded by a fixed time well beyond the slowest correct run.
  initial begin
    #2ms;
    $display("point_in_view_frustum_test: mismatch");
    $finish;
  end

  // Result side: random ready, except during the steady stretch and while a
  // long hold-off is counting down, which fills the pipe and stalls the input.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        res.ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        res.ready <= steady || ($urandom_range(99) >= 35);
      end
    end
  end

  function automatic logic [CFG_W-1:0] pack3(input logic [15:0] x, input logic [15:0] y,
                                             input logic [15:0] z);
    return {z, y, x};
  endfunction

  // Offers one point and holds it until the block takes the beat. Valid stays
  // high between back-to-back beats.
  task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z);
    while (!steady && $urandom_range(99) < 35) begin
      pt.valid <= 1'b0;
      @(posedge clk);
    end
    pt.valid   <= 1'b1;
    pt.point_x <= x;
    pt.point_y <= y;
    pt.point_z <= z;
    do @(posedge clk); while (!pt.ready);
  endtask

  // Valid drops right after the last accepted beat, then every result is
  // awaited before the configuration may change.
  task automatic drain();
    pt.valid <= 1'b0;
    @(posedge clk);
    wait (flags_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en    <= 1'b0;
  endtask

  // Loads a whole setting. Near and far get random upper bits, which the
  // block must discard.
  task automatic load_setting(input logic [CFG_W-1:0] light, input logic [CFG_W-1:0] rt,
                              input logic [CFG_W-1:0] up, input logic [CFG_W-1:0] fwd,
                              input logic [15:0] nearv, input logic [15:0] farv);
    write_reg(pift_pkg::REG_LIGHT_POS, light);
    write_reg(pift_pkg::REG_AXIS_RT, rt);
    write_reg(pift_pkg::REG_AXIS_UP, up);
    write_reg(pift_pkg::REG_AXIS_FWD, fwd);
    write_reg(pift_pkg::REG_NEAR, {32'($urandom()), nearv});
    write_reg(pift_pkg::REG_FAR, {32'($urandom()), farv});
    write_reg(REG_SPARE_A, CFG_W'({$urandom(), $urandom()}));
    write_reg(REG_SPARE_B, CFG_W'({$urandom(), $urandom()}));
  endtask

  function automatic logic [15:0] rand_lane(input int span);
    if (span == 0) return 16'($urandom());
    return 16'($urandom_range(2 * span) - span);
  endfunction

  // Random points: most lie around the light within a random span so that many are
  // inside and the edge comparisons are exercised; the rest cover the range.
  task automatic random_points(input int count, input logic [CFG_W-1:0] light);
    logic [15:0] x, y, z;
    int          span;
    for (int n = 0; n < count; n++) begin
      span = ($urandom_range(3) == 0) ? 0 : (1 << $urandom_range(14, 4));
      x = rand_lane(span);
      y = rand_lane(span);
      z = rand_lane(span);
      if (span != 0) begin
        x = x + light[15:0];
        y = y + light[31:16];
        z = z + light[47:32];
      end
      send_point(x, y, z);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] light, rt, up, fwd;
    logic [15:0]      nearv, farv;
    rst        = 1'b1;
    wr_en      = 1'b0;
    wr_index   = '0;
    wr_data    = '0;
    pt.valid   = 1'b0;
    pt.point_x = '0;
    pt.point_y = '0;
    pt.point_z = '0;
    steady     = 1'b0;
    stall_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats under the reset setting: the light origin, points on the
    // view axis (which looks down negative z), on the 45 degree edges, just
    // past them, behind the light and at the coordinate extremes.
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h0000, 16'h0000, 16'hFF00);
    send_point(16'h0100, 16'h0000, 16'hFF00);
    send_point(16'h0101, 16'h0000, 16'hFF00);
    send_point(16'h0000, 16'hFF00, 16'hFF00);
    send_point(16'h0000, 16'hFEFF, 16'hFF00);
    send_point(16'h0000, 16'h0000, 16'h0100);
    send_point(16'h0000, 16'h0001, 16'h0000);
    send_point(16'h7FFF, 16'h7FFF, 16'h8000);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h7FFF, 16'h8000, 16'h7FFF);
    send_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    // Extreme setting: lanes at both ends and the widest clip span.
    load_setting(pack3(16'h7FFF, 16'h8000, 16'h7FFF), pack3(16'h8000, 16'h8000, 16'h8000),
                 pack3(16'h7FFF, 16'h7FFF, 16'h8000), pack3(16'h8000, 16'h7FFF, 16'h7FFF),
                 16'h8000, 16'h7FFF);
    send_point(16'h8000, 16'h7FFF, 16'h8000);
    send_point(16'h7FFF, 16'h8000, 16'h7FFF);
    send_point(16'h0000, 16'h0000, 16'h0000);
    random_points(40, pack3(16'h7FFF, 16'h8000, 16'h7FFF));
    drain();

    // A zero-length up axis makes every point outside.
    load_setting('0, pift_pkg::RST_AXIS_RT, '0, pift_pkg::RST_AXIS_FWD, 16'h0000, 16'h7FFF);
    send_point(16'h0000, 16'h0000, 16'hFF00);
    send_point(16'h0000, 16'h0000, 16'h0000);
    drain();

    // Near above far rejects everything; zero depth with near at zero.
    load_setting('0, pift_pkg::RST_AXIS_RT, pift_pkg::RST_AXIS_UP, pift_pkg::RST_AXIS_FWD,
                 16'h0200, 16'h0100);
    send_point(16'h0000, 16'h0000, 16'hFE80);
    drain();
    load_setting('0, pift_pkg::RST_AXIS_RT, pift_pkg::RST_AXIS_UP, pift_pkg::RST_AXIS_FWD,
                 16'h0000, 16'h0000);
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h0001, 16'h0000, 16'h0000);
    drain();

    // Random settings. The first keeps both sides busy, then the result side
    // holds off for a long stretch while points keep coming.
    for (int ph = 0; ph < 9; ph++) begin
      light = pack3(rand_lane(4096), rand_lane(4096), rand_lane(4096));
      case ($urandom_range(3))
        0: begin
          rt  = pack3(16'($urandom_range(1, 600)), 16'h0000, 16'h0000);
          up  = pack3(16'h0000, 16'($urandom_range(1, 600)), 16'h0000);
          fwd = pack3(16'h0000, 16'h0000, 16'($urandom_range(1, 600)));
        end
        1: begin
          rt  = pack3(rand_lane(512), rand_lane(512), rand_lane(512));
          up  = pack3(rand_lane(512), rand_lane(512), rand_lane(512));
          fwd = pack3(rand_lane(512), rand_lane(512), rand_lane(512));
        end
        default: begin
          rt  = CFG_W'({$urandom(), $urandom()});
          up  = CFG_W'({$urandom(), $urandom()});
          fwd = CFG_W'({$urandom(), $urandom()});
        end
      endcase
      nearv = ($urandom_range(1) == 0) ? rand_lane(256) : 16'($urandom());
      farv  = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(32767, 256));
      load_setting(light, rt, up, fwd, nearv, farv);
      if (ph == 0) begin
        steady = 1'b1;
        random_points(60, light);
        steady = 1'b0;
      end
      if (ph == 1) stall_left = 80;
      random_points(130, light);
      drain();
    end

    if (fail_count == 0) begin
      $display("point_in_view_frustum_test: match");
    end else begin
      $display("point_in_view_frustum_test: mismatch");
    end
    $finish;
  end
endmodule
